FILE: rtl/core/klpr_pkg.sv
// Shared types and constants for the key press / long press / repeat event block.
package klpr_pkg;

  // Field widths
  localparam int unsigned TickW  = 32;
  localparam int unsigned KeyW   = 5;
  localparam int unsigned KindW  = 2;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_UP_KEY     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DOWN_KEY   = 2'd3;

  // Register reset values
  localparam logic [TimeW-1:0] LONG_PRESS_RST = 16'd500;
  localparam logic [TimeW-1:0] REPEAT_RST     = 16'd100;
  localparam logic [KeyW-1:0]  UP_KEY_RST     = 5'd0;
  localparam logic [KeyW-1:0]  DOWN_KEY_RST   = 5'd1;

  // Event kinds
  localparam logic [KindW-1:0] KIND_PRESSED  = 2'd0;
  localparam logic [KindW-1:0] KIND_RELEASED = 2'd1;
  localparam logic [KindW-1:0] KIND_LONG     = 2'd2;
  localparam logic [KindW-1:0] KIND_REPEAT   = 2'd3;

  // Key phase, one-hot
  typedef enum logic [3:0] {
    PH_RELEASED = 4'b0001,
    PH_PRESSED  = 4'b0010,
    PH_LONG     = 4'b0100,
    PH_REPEAT   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [TimeW-1:0] long_press_ticks;
    logic [TimeW-1:0] repeat_ticks;
    logic [KeyW-1:0]  up_key_code;
    logic [KeyW-1:0]  down_key_code;
  } cfg_t;

  typedef struct packed {
    logic [TickW-1:0] current_tick;
    logic             key_present;
    logic [KeyW-1:0]  key_code;
  } poll_t;

  typedef struct packed {
    logic             event_valid;
    logic [KeyW-1:0]  event_key;
    logic [KindW-1:0] event_kind;
  } event_t;

endpackage

FILE: rtl/core/key_long_press_repeat_events.sv
// Each accepted poll beat passes the input register, then the result register.
// One poll per cycle unless out_stall holds; each gives exactly one result beat.
// The input register and the result register form a two-stage pipeline that
// advances whenever the result register is empty or being taken.
// Reset (synchronous, rst_n low) empties both stages, returns the key phase to
// released, clears the held key and start ticks and loads register defaults.
module key_long_press_repeat_events (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [klpr_pkg::TickW-1:0]    in_current_tick,
  input  logic                          in_key_present,
  input  logic [klpr_pkg::KeyW-1:0]     in_key_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_event_valid,
  output logic [klpr_pkg::KeyW-1:0]     out_event_key,
  output logic [klpr_pkg::KindW-1:0]    out_event_kind,
  input  logic                          cfg_we,
  input  logic [klpr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [klpr_pkg::CfgDataW-1:0] cfg_wdata
);
  import klpr_pkg::*;

  cfg_t   cfg;
  poll_t  poll_r;
  logic   poll_valid_r;
  event_t evt;
  event_t evt_r;
  logic   evt_valid_r;
  logic   out_free;
  logic   advance;
  logic   in_take;

  // Pipeline flow control
  assign out_free = !evt_valid_r || !out_stall;
  assign advance  = poll_valid_r && out_free;
  assign in_stall = poll_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  klpr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_valid_r <= 1'b0;
    end else if (in_take) begin
      poll_valid_r <= 1'b1;
    end else if (advance) begin
      poll_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      poll_r.current_tick <= in_current_tick;
      poll_r.key_present  <= in_key_present;
      poll_r.key_code     <= in_key_code;
    end
  end

  klpr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .poll    (poll_r),
    .cfg     (cfg),
    .evt     (evt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evt_valid_r <= 1'b0;
    end else if (advance) begin
      evt_valid_r <= 1'b1;
    end else if (!out_stall) begin
      evt_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      evt_r <= evt;
    end
  end

  assign out_valid       = evt_valid_r;
  assign out_event_valid = evt_r.event_valid;
  assign out_event_key   = evt_r.event_key;
  assign out_event_kind  = evt_r.event_kind;

endmodule

FILE: rtl/core/klpr_cfg.sv
// Configuration register file for the key event block.
module klpr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [klpr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [klpr_pkg::CfgDataW-1:0] cfg_wdata,
  output klpr_pkg::cfg_t                cfg
);
  import klpr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index and take the write data
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONG_PRESS: cfg_nxt.long_press_ticks = cfg_wdata[TimeW-1:0];
        CFG_REPEAT:     cfg_nxt.repeat_ticks     = cfg_wdata[TimeW-1:0];
        CFG_UP_KEY:     cfg_nxt.up_key_code      = cfg_wdata[KeyW-1:0];
        CFG_DOWN_KEY:   cfg_nxt.down_key_code    = cfg_wdata[KeyW-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks <= LONG_PRESS_RST;
      cfg_r.repeat_ticks     <= REPEAT_RST;
      cfg_r.up_key_code      <= UP_KEY_RST;
      cfg_r.down_key_code    <= DOWN_KEY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/core/klpr_core.sv
// Key phase state machine: one poll in, at most one event out.
module klpr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  klpr_pkg::poll_t  poll,
  input  klpr_pkg::cfg_t   cfg,
  output klpr_pkg::event_t evt
);
  import klpr_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [KeyW-1:0]  held_key_r, held_key_nxt;
  logic [TickW-1:0] press_start_r, press_start_nxt;
  logic [TickW-1:0] repeat_start_r, repeat_start_nxt;

  logic [TickW-1:0] press_elapsed;
  logic [TickW-1:0] repeat_elapsed;
  logic             long_due;
  logic             repeat_due;
  logic             nav_key;

  // Elapsed time wraps modulo the tick width
  assign press_elapsed  = poll.current_tick - press_start_r;
  assign repeat_elapsed = poll.current_tick - repeat_start_r;
  assign long_due   = press_elapsed  >= {{(TickW-TimeW){1'b0}}, cfg.long_press_ticks};
  assign repeat_due = repeat_elapsed >= {{(TickW-TimeW){1'b0}}, cfg.repeat_ticks};
  assign nav_key    = (held_key_r == cfg.up_key_code) || (held_key_r == cfg.down_key_code);

  // Next phase and event for this poll
  always_comb begin
    phase_nxt        = phase_r;
    held_key_nxt     = held_key_r;
    press_start_nxt  = press_start_r;
    repeat_start_nxt = repeat_start_r;
    evt              = '0;
    unique case (phase_r) inside
      PH_RELEASED: begin
        if (poll.key_present) begin
          evt.event_valid = 1'b1;
          evt.event_key   = poll.key_code;
          evt.event_kind  = KIND_PRESSED;
          phase_nxt       = PH_PRESSED;
          press_start_nxt = poll.current_tick;
          held_key_nxt    = poll.key_code;
        end
      end
      PH_PRESSED: begin
        if (poll.key_present) begin
          if (long_due) begin
            evt.event_valid  = 1'b1;
            evt.event_key    = poll.key_code;
            evt.event_kind   = KIND_LONG;
            press_start_nxt  = '0;
            phase_nxt        = PH_LONG;
            repeat_start_nxt = poll.current_tick;
          end
        end else begin
          evt.event_valid = 1'b1;
          evt.event_key   = held_key_r;
          evt.event_kind  = KIND_RELEASED;
          press_start_nxt = '0;
          phase_nxt       = PH_RELEASED;
          held_key_nxt    = '0;
        end
      end
      PH_LONG, PH_REPEAT: begin
        if (poll.key_present) begin
          if (repeat_due) begin
            evt.event_valid  = 1'b1;
            evt.event_key    = poll.key_code;
            evt.event_kind   = KIND_REPEAT;
            repeat_start_nxt = poll.current_tick;
            phase_nxt        = PH_REPEAT;
          end
        end else begin
          // Release after a long press is reported only for repeating nav keys
          if ((phase_r == PH_REPEAT) && nav_key) begin
            evt.event_valid = 1'b1;
            evt.event_key   = held_key_r;
            evt.event_kind  = KIND_RELEASED;
          end
          press_start_nxt = '0;
          phase_nxt       = PH_RELEASED;
          held_key_nxt    = '0;
        end
      end
      default: begin
        phase_nxt = PH_RELEASED;
      end
    endcase
  end

  // Commit state when the poll moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_RELEASED;
      held_key_r     <= '0;
      press_start_r  <= '0;
      repeat_start_r <= '0;
    end else if (advance) begin
      phase_r        <= phase_nxt;
      held_key_r     <= held_key_nxt;
      press_start_r  <= press_start_nxt;
      repeat_start_r <= repeat_start_nxt;
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for key_long_press_repeat_events: drives key polls, predicts key events.
module testbench;
  import klpr_pkg::*;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [TickW-1:0]    in_current_tick = '0;
  logic                in_key_present = 1'b0;
  logic [KeyW-1:0]     in_key_code = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_event_valid;
  logic [KeyW-1:0]     out_event_key;
  logic [KindW-1:0]    out_event_kind;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_LONG_PRESS;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // Register copies kept by the bench
  logic [TimeW-1:0] long_thr = LONG_PRESS_RST;
  logic [TimeW-1:0] rpt_thr = REPEAT_RST;
  logic [KeyW-1:0]  up_code = UP_KEY_RST;
  logic [KeyW-1:0]  down_code = DOWN_KEY_RST;

  // Key tracking state of the predictor
  phase_t           hold_phase = PH_RELEASED;
  logic [KeyW-1:0]  hold_key = '0;
  logic [TickW-1:0] hold_start = '0;
  logic [TickW-1:0] rpt_start = '0;

  poll_t            poll_queue[$];
  event_t           expected_events[$];
  poll_t            drv_poll = '0;
  bit               poll_held = 1'b0;
  int unsigned      burst_left = 1;
  int unsigned      gap_left = 0;
  int unsigned      errors = 0;
  int unsigned      queued_polls = 0;
  logic [TickW-1:0] tick_now = '0;
  stall_mode_t      stall_mode = STALL_NONE;
  int unsigned      stall_cnt = 0;

  always #1 clk = ~clk;

  key_long_press_repeat_events dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_current_tick (in_current_tick),
    .in_key_present  (in_key_present),
    .in_key_code     (in_key_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_valid (out_event_valid),
    .out_event_key   (out_event_key),
    .out_event_kind  (out_event_kind),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Advance the key tracker by one poll and queue the event it should give
  task automatic predict_key_event(input poll_t p);
    event_t           ev;
    logic [TickW-1:0] since;
    ev = '0;
    if (p.key_present) begin
      case (hold_phase)
        PH_RELEASED: begin
          ev.event_valid = 1'b1;
          ev.event_key   = p.key_code;
          ev.event_kind  = KIND_PRESSED;
          hold_phase     = PH_PRESSED;
          hold_start     = p.current_tick;
          hold_key       = p.key_code;
        end
        PH_PRESSED: begin
          since = p.current_tick - hold_start;
          if (since >= TickW'(long_thr)) begin
            ev.event_valid = 1'b1;
            ev.event_key   = p.key_code;
            ev.event_kind  = KIND_LONG;
            hold_start     = '0;
            hold_phase     = PH_LONG;
            rpt_start      = p.current_tick;
          end
        end
        default: begin
          since = p.current_tick - rpt_start;
          if (since >= TickW'(rpt_thr)) begin
            ev.event_valid = 1'b1;
            ev.event_key   = p.key_code;
            ev.event_kind  = KIND_REPEAT;
            rpt_start      = p.current_tick;
            hold_phase     = PH_REPEAT;
          end
        end
      endcase
    end else if (hold_phase != PH_RELEASED) begin
      // Release after a long press only counts for up/down keys that were repeating
      if (hold_phase == PH_PRESSED ||
          (hold_phase == PH_REPEAT && (hold_key == up_code || hold_key == down_code))) begin
        ev.event_valid = 1'b1;
        ev.event_key   = hold_key;
        ev.event_kind  = KIND_RELEASED;
      end
      hold_start = '0;
      hold_phase = PH_RELEASED;
      hold_key   = '0;
    end
    expected_events.push_back(ev);
  endtask

  task automatic push_poll(input logic [TickW-1:0] tick, input logic present,
                           input logic [KeyW-1:0] code);
    poll_t p;
    p.current_tick = tick;
    p.key_present  = present;
    p.key_code     = code;
    poll_queue.push_back(p);
    queued_polls++;
  endtask

  // Queue one press: hold polls timed around the thresholds, then a release
  task automatic add_press_run();
    logic [KeyW-1:0]  key;
    logic [TickW-1:0] mark_tick;
    logic [TickW-1:0] thr;
    logic [TickW-1:0] elapsed;
    logic [TickW-1:0] target;
    bit               long_seen;
    int unsigned      holds;
    case ($urandom_range(0, 4))
      0, 1: key = up_code;
      2, 3: key = down_code;
      default: key = KeyW'($urandom_range(0, 31));
    endcase
    case ($urandom_range(0, 3))
      0: tick_now = $urandom();
      1: tick_now = 32'hFFFF_FFFF - $urandom_range(0, long_thr + 2);
      default: tick_now = tick_now + $urandom_range(1, 5000);
    endcase
    push_poll(tick_now, 1'b1, key);
    mark_tick = tick_now;
    long_seen = 1'b0;
    holds = $urandom_range(0, 10);
    for (int i = 0; i < holds; i++) begin
      thr = long_seen ? TickW'(rpt_thr) : TickW'(long_thr);
      elapsed = tick_now - mark_tick;
      case ($urandom_range(0, 4))
        0: target = (thr == 0) ? '0 : thr - 1;
        1: target = thr;
        2: target = thr + $urandom_range(0, 3);
        3: target = $urandom_range(0, 2 * thr);
        default: target = elapsed + $urandom_range(0, 2);
      endcase
      if (target < elapsed)
        target = elapsed;
      tick_now = mark_tick + target;
      // Swap the scanned key now and then while held
      if ($urandom_range(0, 6) == 0)
        key = KeyW'($urandom_range(0, 31));
      push_poll(tick_now, 1'b1, key);
      if (tick_now - mark_tick >= thr) begin
        mark_tick = tick_now;
        long_seen = 1'b1;
      end
    end
    tick_now = tick_now + $urandom_range(0, 50);
    push_poll(tick_now, 1'b0, KeyW'($urandom_range(0, 31)));
    if ($urandom_range(0, 3) == 0)
      push_poll(tick_now + 1, 1'b0, KeyW'($urandom_range(0, 31)));
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned goal;
    int unsigned cnt;
    goal = queued_polls + n;
    while (queued_polls < goal) begin
      if ($urandom_range(0, 9) < 8) begin
        add_press_run();
      end else begin
        cnt = $urandom_range(1, 4);
        for (int i = 0; i < cnt; i++)
          push_poll($urandom(), 1'($urandom_range(0, 1)), KeyW'($urandom_range(0, 31)));
      end
    end
  endtask

  // Hold until every queued poll is taken and every event has come out
  task automatic wait_idle();
    while (poll_queue.size() != 0 || poll_held || expected_events.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CfgDataW-1:0] lp, input logic [CfgDataW-1:0] rp,
                               input logic [CfgDataW-1:0] up_wd,
                               input logic [CfgDataW-1:0] down_wd);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LONG_PRESS;
    cfg_wdata <= lp;
    long_thr  = lp;
    @(posedge clk);
    cfg_index <= CFG_REPEAT;
    cfg_wdata <= rp;
    rpt_thr   = rp;
    @(posedge clk);
    cfg_index <= CFG_UP_KEY;
    cfg_wdata <= up_wd;
    up_code   = up_wd[KeyW-1:0];
    @(posedge clk);
    cfg_index <= CFG_DOWN_KEY;
    cfg_wdata <= down_wd;
    down_code = down_wd[KeyW-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Driver: feed poll beats in bursts with random gaps
  always @(posedge clk) begin : driver
    poll_t nxt;
    logic  nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Retire the beat taken at this edge
      if (in_valid && !in_stall) begin
        predict_key_event(drv_poll);
        poll_held = 1'b0;
      end
      if (!poll_held) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (poll_queue.size() > 0) begin
          nxt = poll_queue.pop_front();
          drv_poll = nxt;
          poll_held = 1'b1;
          nv = 1'b1;
          in_current_tick <= nxt.current_tick;
          in_key_present  <= nxt.key_present;
          in_key_code     <= nxt.key_code;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = 1;
              2: gap_left = $urandom_range(1, 4);
              default: gap_left = $urandom_range(5, 12);
            endcase
          end
        end
        in_valid <= nv;
      end
    end
  end

  // Monitor: check each result beat and drive the stall pattern
  always @(posedge clk) begin : monitor
    event_t exp_ev;
    logic   ns;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: valid %0d key %0d kind %0d", $time,
                   out_event_valid, out_event_key, out_event_kind);
        end else begin
          exp_ev = expected_events.pop_front();
          if (out_event_valid !== exp_ev.event_valid) begin
            errors++;
            $display("%0t: event_valid expected %0d, got %0d", $time,
                     exp_ev.event_valid, out_event_valid);
          end
          if (out_event_key !== exp_ev.event_key) begin
            errors++;
            $display("%0t: event_key expected %0d, got %0d", $time,
                     exp_ev.event_key, out_event_key);
          end
          if (out_event_kind !== exp_ev.event_kind) begin
            errors++;
            $display("%0t: event_kind expected %0d, got %0d", $time,
                     exp_ev.event_kind, out_event_kind);
          end
        end
      end
      // Switch to a new random stall pattern periodically
      stall_cnt++;
      if (stall_cnt % 48 == 0)
        stall_mode = stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:  ns = 1'b0;
        STALL_LIGHT: ns = ($urandom_range(0, 9) < 3);
        STALL_HEAVY: ns = ($urandom_range(0, 9) < 7);
        default:     ns = ((stall_cnt / 4) % 2 == 1);
      endcase
      out_stall <= ns;
    end
  end

  // Stimulus sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed polls at reset settings; first press wraps the tick
    push_poll(32'd0, 1'b0, 5'd31);
    push_poll(32'hFFFF_FFFF, 1'b1, 5'd31);
    push_poll(32'h0000_01F2, 1'b1, 5'd31);
    push_poll(32'h0000_01F3, 1'b1, 5'd31);
    push_poll(32'h0000_0256, 1'b1, 5'd31);
    push_poll(32'h0000_0257, 1'b1, 5'd31);
    push_poll(32'h0000_0258, 1'b0, 5'd0);
    // Up key repeating, scanned key swapped while held, release reported
    push_poll(32'd1000, 1'b1, 5'd0);
    push_poll(32'd1500, 1'b1, 5'd0);
    push_poll(32'd1600, 1'b1, 5'd0);
    push_poll(32'd1700, 1'b1, 5'd2);
    push_poll(32'd1701, 1'b0, 5'd31);
    // Short press and release
    push_poll(32'd2000, 1'b1, 5'd1);
    push_poll(32'd2001, 1'b0, 5'd1);
    // Long press without repeat: release is silent
    push_poll(32'd3000, 1'b1, 5'd1);
    push_poll(32'd3500, 1'b1, 5'd1);
    push_poll(32'd3501, 1'b0, 5'd0);
    // Down key repeating, release reported
    push_poll(32'd4000, 1'b1, 5'd1);
    push_poll(32'd4500, 1'b1, 5'd1);
    push_poll(32'd4600, 1'b1, 5'd1);
    push_poll(32'd4601, 1'b0, 5'd0);
    // Long press names the scanned key, not the held one
    push_poll(32'd0, 1'b1, 5'd9);
    push_poll(32'd600, 1'b1, 5'd22);
    push_poll(32'd601, 1'b0, 5'd22);
    wait_idle();

    run_random(150);
    wait_idle();

    apply_setting(16'd1, 16'd1, 16'd31, 16'd30);
    run_random(130);
    wait_idle();

    // Zero thresholds, same up and down key, junk in upper data bits
    apply_setting(16'd0, 16'd0, 16'hFFE5, 16'hA5A5);
    run_random(130);
    wait_idle();

    apply_setting(16'hFFFF, 16'hFFFF, 16'd0, 16'd31);
    run_random(130);
    wait_idle();

    apply_setting(CfgDataW'($urandom_range(1, 2000)), CfgDataW'($urandom_range(1, 500)),
                  CfgDataW'($urandom_range(0, 31)), CfgDataW'($urandom_range(0, 31)));
    run_random(65);
    wait_idle();
    run_random(65);
    wait_idle();

    apply_setting(CfgDataW'($urandom_range(0, 65535)), CfgDataW'($urandom_range(0, 65535)),
                  CfgDataW'($urandom_range(0, 65535)), CfgDataW'($urandom_range(0, 65535)));
    run_random(130);
    wait_idle();

    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("key_long_press_repeat_events test passed");
    else
      $display("key_long_press_repeat_events test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("key_long_press_repeat_events test failed");
    $finish;
  end

endmodule
